>>> hdl/dsf_pkg.sv
// Shared constants, types and register codes of the damped spring force unit.
package dsf_pkg;

	localparam int unsigned POS_W       = 15;
	localparam int unsigned VEL_W       = 16;
	localparam int unsigned FORCE_W     = 26;
	localparam int unsigned DIFF_W      = 16;
	localparam int unsigned ADIFF_W     = 15;
	localparam int unsigned DV_W        = 17;
	localparam int unsigned SQ_W        = 32;
	localparam int unsigned DOT_W       = 34;
	localparam int unsigned ADOT_W      = 33;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned AFORCE_W    = 24;
	localparam int unsigned DSM_W       = 49;
	localparam int unsigned EL_W        = 39;
	localparam int unsigned NUM_W       = 64;
	localparam int unsigned DEN_W       = 40;
	localparam int unsigned QUO_W       = 26;
	localparam int unsigned DIV_LANES   = 4;
	localparam int unsigned SQRT_STAGES = 16;
	localparam int unsigned CFG_ADDR_W  = 4;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned FIFO_DEPTH  = 2;
	localparam int unsigned CNT_W       = 2;

	localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};
	localparam logic [QUO_W-1:0] NEG_MAG_MAX = {1'b1, {(QUO_W-1){1'b0}}};
	localparam logic [QUO_W-1:0] POS_MAG_MAX = {1'b0, {(QUO_W-1){1'b1}}};

	typedef enum logic [1:0] {
		REG_REST_LEN  = 2'd0,
		REG_STIFFNESS = 2'd1,
		REG_DAMPING   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] rest_len;
		logic [7:0]  stiffness;
		logic [15:0] damping_q8_8;
	} cfg_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DOT_W-1:0]  dot;
		logic                     coin;
	} sq_side_t;

	typedef struct packed {
		logic e_neg_x;
		logic e_neg_y;
		logic d_neg_x;
		logic d_neg_y;
		logic ovf_x;
		logic ovf_y;
		logic coin;
	} div_side_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] elastic_fx;
		logic signed [FORCE_W-1:0] elastic_fy;
		logic signed [FORCE_W-1:0] damp_fx;
		logic signed [FORCE_W-1:0] damp_fy;
		logic                      coincident;
	} res_t;

endpackage

>>> hdl/dsf_ifs.sv
// Item and result channel interfaces of the damped spring force unit.
interface dsf_item_if;
	logic valid;
	logic ready;
	logic signed [dsf_pkg::POS_W-1:0] first_x;
	logic signed [dsf_pkg::POS_W-1:0] first_y;
	logic signed [dsf_pkg::POS_W-1:0] second_x;
	logic signed [dsf_pkg::POS_W-1:0] second_y;
	logic signed [dsf_pkg::VEL_W-1:0] first_vx;
	logic signed [dsf_pkg::VEL_W-1:0] first_vy;
	logic signed [dsf_pkg::VEL_W-1:0] second_vx;
	logic signed [dsf_pkg::VEL_W-1:0] second_vy;

	modport source (output valid, first_x, first_y, second_x, second_y,
		first_vx, first_vy, second_vx, second_vy, input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y,
		first_vx, first_vy, second_vx, second_vy, output ready);
endinterface

interface dsf_result_if;
	logic valid;
	logic ready;
	logic signed [dsf_pkg::FORCE_W-1:0] elastic_fx;
	logic signed [dsf_pkg::FORCE_W-1:0] elastic_fy;
	logic signed [dsf_pkg::FORCE_W-1:0] damp_fx;
	logic signed [dsf_pkg::FORCE_W-1:0] damp_fy;
	logic coincident;

	modport source (output valid, elastic_fx, elastic_fy, damp_fx, damp_fy, coincident,
		input ready);
	modport sink (input valid, elastic_fx, elastic_fy, damp_fx, damp_fy, coincident,
		output ready);
endinterface

>>> hdl/damped_spring_force_unit.sv
// Top level of the damped spring force unit: front end, length, force terms, output buffer.
// Throughput: one beat per cycle while the output buffer has room; 3 difference/product
// stages, 16 square root stages, 3 force stages and 26 divider stages, followed by a
// two-entry output buffer. The item side stalls only while that output buffer is full.
// Reset clears all valid bits, the buffer and sets the registers to their reset values.
module damped_spring_force_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	dsf_item_if.sink                        item,
	dsf_result_if.source                    result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dsf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [dsf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [dsf_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int unsigned DFW = dsf_pkg::DIFF_W;
	localparam int unsigned DVW = dsf_pkg::DV_W;
	localparam int unsigned SW  = dsf_pkg::SQ_W;
	localparam int unsigned OW  = dsf_pkg::DOT_W;
	localparam int unsigned LW  = dsf_pkg::LEN_W;
	localparam int unsigned FW  = dsf_pkg::FORCE_W;
	localparam int unsigned NW  = dsf_pkg::NUM_W;
	localparam int unsigned DW  = dsf_pkg::DEN_W;
	localparam int unsigned QW  = dsf_pkg::QUO_W;

	dsf_pkg::cfg_t cfg;

	dsf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic en;
	logic [dsf_pkg::CNT_W-1:0] cnt_q;

	assign en         = cnt_q != dsf_pkg::CNT_W'(dsf_pkg::FIFO_DEPTH);
	assign item.ready = en;

	// differences
	logic                  v_s1;
	logic signed [DFW-1:0] dx_s1, dy_s1;
	logic signed [DVW-1:0] dvx_s1, dvy_s1;

	// squares and dot products
	logic                  v_s2;
	logic [SW-1:0]         sqx_s2, sqy_s2;
	logic signed [OW-1:0]  px_s2, py_s2;
	logic signed [DFW-1:0] dx_s2, dy_s2;
	logic                  coin_s2;

	// sums
	logic                  v_s3;
	logic [SW-1:0]         dsq_s3;
	dsf_pkg::sq_side_t     side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DFW'(item.second_x) - DFW'(item.first_x);
			dy_s1  <= DFW'(item.second_y) - DFW'(item.first_y);
			dvx_s1 <= DVW'(item.second_vx) - DVW'(item.first_vx);
			dvy_s1 <= DVW'(item.second_vy) - DVW'(item.first_vy);

			sqx_s2  <= SW'(dx_s1) * SW'(dx_s1);
			sqy_s2  <= SW'(dy_s1) * SW'(dy_s1);
			px_s2   <= OW'(dvx_s1) * OW'(dx_s1);
			py_s2   <= OW'(dvy_s1) * OW'(dy_s1);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			coin_s2 <= (dx_s1 == '0) && (dy_s1 == '0);

			dsq_s3       <= sqx_s2 + sqy_s2;
			side_s3.dot  <= px_s2 + py_s2;
			side_s3.dx   <= dx_s2;
			side_s3.dy   <= dy_s2;
			side_s3.coin <= coin_s2;
		end
	end

	logic              sq_v;
	logic [LW-1:0]     sq_root;
	dsf_pkg::sq_side_t sq_side;

	dsf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_rad    (dsq_s3),
		.in_side   (side_s3),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// spring force, length squared, damping scale
	logic signed [LW+1:0]              ldiff;
	logic [OW-1:0]                     dot_mag;
	logic [DFW-1:0]                    dxm, dym;
	logic                              v_s4;
	logic signed [FW-1:0]              force_s4;
	logic [SW-1:0]                     den0_s4;
	logic [dsf_pkg::DSM_W-1:0]         dsm_s4;
	logic [dsf_pkg::ADIFF_W-1:0]       adx_s4, ady_s4;
	logic [LW-1:0]                     len_s4;
	logic                              sx_s4, sy_s4, sdot_s4, coin_s4;

	assign ldiff   = $signed({2'b00, sq_root}) - $signed({2'b00, cfg.rest_len});
	assign dot_mag = sq_side.dot[OW-1] ? OW'(-sq_side.dot) : OW'(sq_side.dot);
	assign dxm     = sq_side.dx[DFW-1] ? DFW'(-sq_side.dx) : DFW'(sq_side.dx);
	assign dym     = sq_side.dy[DFW-1] ? DFW'(-sq_side.dy) : DFW'(sq_side.dy);

	// numerators
	logic [FW-1:0]        force_mag;
	logic                 v_s5;
	logic [dsf_pkg::EL_W-1:0] enx_s5, eny_s5;
	logic [NW-1:0]        dnx_s5, dny_s5;
	logic [DW-1:0]        den_s5;
	logic [LW-1:0]        len_s5;
	dsf_pkg::div_side_t   side_s5;

	assign force_mag = force_s4[FW-1] ? FW'(-force_s4) : FW'(force_s4);

	// overflow check
	logic                 ovfx, ovfy;
	logic                 v_s6;
	logic [dsf_pkg::EL_W-1:0] enx_s6, eny_s6;
	logic [NW-1:0]        dnx_s6, dny_s6;
	logic [DW-1:0]        den_s6;
	logic [LW-1:0]        len_s6;
	dsf_pkg::div_side_t   side_s6;

	assign ovfx = {2'b00, dnx_s5} >= {den_s5, {QW{1'b0}}};
	assign ovfy = {2'b00, dny_s5} >= {den_s5, {QW{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_s4 <= FW'(ldiff) * FW'($signed({1'b0, cfg.stiffness}));
			den0_s4  <= SW'(sq_root) * SW'(sq_root);
			dsm_s4   <= dsf_pkg::DSM_W'(dot_mag[dsf_pkg::ADOT_W-1:0]) *
				dsf_pkg::DSM_W'(cfg.damping_q8_8);
			adx_s4   <= dxm[dsf_pkg::ADIFF_W-1:0];
			ady_s4   <= dym[dsf_pkg::ADIFF_W-1:0];
			len_s4   <= sq_root;
			sx_s4    <= sq_side.dx[DFW-1];
			sy_s4    <= sq_side.dy[DFW-1];
			sdot_s4  <= sq_side.dot[OW-1];
			coin_s4  <= sq_side.coin;

			enx_s5  <= dsf_pkg::EL_W'(adx_s4) *
				dsf_pkg::EL_W'(force_mag[dsf_pkg::AFORCE_W-1:0]);
			eny_s5  <= dsf_pkg::EL_W'(ady_s4) *
				dsf_pkg::EL_W'(force_mag[dsf_pkg::AFORCE_W-1:0]);
			dnx_s5  <= NW'(adx_s4) * NW'(dsm_s4);
			dny_s5  <= NW'(ady_s4) * NW'(dsm_s4);
			den_s5  <= {den0_s4, 8'b0};
			len_s5  <= len_s4;
			side_s5.e_neg_x <= sx_s4 ^ force_s4[FW-1];
			side_s5.e_neg_y <= sy_s4 ^ force_s4[FW-1];
			side_s5.d_neg_x <= sx_s4 ^ sdot_s4;
			side_s5.d_neg_y <= sy_s4 ^ sdot_s4;
			side_s5.coin    <= coin_s4;

			enx_s6  <= enx_s5;
			eny_s6  <= eny_s5;
			dnx_s6  <= ovfx ? '0 : dnx_s5;
			dny_s6  <= ovfy ? '0 : dny_s5;
			den_s6  <= den_s5;
			len_s6  <= len_s5;
			side_s6.e_neg_x <= side_s5.e_neg_x;
			side_s6.e_neg_y <= side_s5.e_neg_y;
			side_s6.d_neg_x <= side_s5.d_neg_x;
			side_s6.d_neg_y <= side_s5.d_neg_y;
			side_s6.ovf_x   <= ovfx;
			side_s6.ovf_y   <= ovfy;
			side_s6.coin    <= side_s5.coin;
		end
	end

	logic [NW-1:0]      div_num [dsf_pkg::DIV_LANES];
	logic [DW-1:0]      div_den [dsf_pkg::DIV_LANES];
	logic [QW-1:0]      div_quo [dsf_pkg::DIV_LANES];
	logic               div_v;
	dsf_pkg::div_side_t div_side;

	assign div_num[0] = NW'(enx_s6);
	assign div_num[1] = NW'(eny_s6);
	assign div_num[2] = dnx_s6;
	assign div_num[3] = dny_s6;
	assign div_den[0] = DW'(len_s6);
	assign div_den[1] = DW'(len_s6);
	assign div_den[2] = den_s6;
	assign div_den[3] = den_s6;

	dsf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_num    (div_num),
		.in_den    (div_den),
		.in_side   (side_s6),
		.out_valid (div_v),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	function automatic logic signed [FW-1:0] damp_sat(logic [QW-1:0] q, logic neg, logic ovf);
		logic signed [FW-1:0] r;
		if (ovf) begin
			r = neg ? dsf_pkg::FORCE_MIN : dsf_pkg::FORCE_MAX;
		end else if (neg) begin
			r = (q > dsf_pkg::NEG_MAG_MAX) ? dsf_pkg::FORCE_MIN : $signed(-q);
		end else begin
			r = (q > dsf_pkg::POS_MAG_MAX) ? dsf_pkg::FORCE_MAX : $signed(q);
		end
		return r;
	endfunction

	dsf_pkg::res_t res_nxt;

	always_comb begin
		res_nxt.coincident = div_side.coin;
		if (div_side.coin) begin
			res_nxt.elastic_fx = '0;
			res_nxt.elastic_fy = '0;
			res_nxt.damp_fx    = '0;
			res_nxt.damp_fy    = '0;
		end else begin
			res_nxt.elastic_fx = div_side.e_neg_x ? $signed(-div_quo[0]) : $signed(div_quo[0]);
			res_nxt.elastic_fy = div_side.e_neg_y ? $signed(-div_quo[1]) : $signed(div_quo[1]);
			res_nxt.damp_fx    = damp_sat(div_quo[2], div_side.d_neg_x, div_side.ovf_x);
			res_nxt.damp_fy    = damp_sat(div_quo[3], div_side.d_neg_y, div_side.ovf_y);
		end
	end

	// output buffer
	dsf_pkg::res_t buf_q [dsf_pkg::FIFO_DEPTH];
	logic          wptr_q, rptr_q;
	logic          push, pop;

	assign push = en && div_v;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + dsf_pkg::CNT_W'(push) - dsf_pkg::CNT_W'(pop);
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= res_nxt;
		end
	end

	assign result.valid      = cnt_q != '0;
	assign result.elastic_fx = buf_q[rptr_q].elastic_fx;
	assign result.elastic_fy = buf_q[rptr_q].elastic_fy;
	assign result.damp_fx    = buf_q[rptr_q].damp_fx;
	assign result.damp_fy    = buf_q[rptr_q].damp_fy;
	assign result.coincident = buf_q[rptr_q].coincident;

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> v_s1)
		else $error("accepted beat did not enter the first stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s3) && $stable(v_s6))
		else $error("pipeline moved during a stall");
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dsf_pkg::CNT_W'(dsf_pkg::FIFO_DEPTH))
		else $error("output buffer overfilled");
	a_coin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.coincident |-> result.elastic_fx == '0 &&
		result.elastic_fy == '0 && result.damp_fx == '0 && result.damp_fy == '0)
		else $error("coincident beat with nonzero force");
`endif

endmodule

>>> hdl/dsf_cfg.sv
// APB configuration registers of the damped spring force unit.
module dsf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dsf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [dsf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [dsf_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	output dsf_pkg::cfg_t                   cfg
);

	logic [15:0] rest_q;
	logic [7:0]  stiff_q;
	logic [15:0] damp_q;
	logic        wr;
	dsf_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = dsf_pkg::reg_idx_t'(paddr[dsf_pkg::CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= 16'd0;
			stiff_q <= 8'd1;
			damp_q  <= 16'd0;
		end else if (wr) begin
			case (idx)
				dsf_pkg::REG_REST_LEN:  rest_q  <= pwdata[15:0];
				dsf_pkg::REG_STIFFNESS: stiff_q <= pwdata[7:0];
				dsf_pkg::REG_DAMPING:   damp_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dsf_pkg::REG_REST_LEN:  prdata = dsf_pkg::CFG_DATA_W'(rest_q);
			dsf_pkg::REG_STIFFNESS: prdata = dsf_pkg::CFG_DATA_W'(stiff_q);
			dsf_pkg::REG_DAMPING:   prdata = dsf_pkg::CFG_DATA_W'(damp_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.rest_len     = rest_q;
	assign cfg.stiffness    = stiff_q;
	assign cfg.damping_q8_8 = damp_q;

endmodule

>>> hdl/dsf_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module dsf_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [dsf_pkg::SQ_W-1:0]  in_rad,
	input  dsf_pkg::sq_side_t         in_side,
	output logic                      out_valid,
	output logic [dsf_pkg::LEN_W-1:0] out_root,
	output dsf_pkg::sq_side_t         out_side
);

	localparam int unsigned SW = dsf_pkg::SQ_W;
	localparam int unsigned NS = dsf_pkg::SQRT_STAGES;

	logic              v_s    [NS];
	logic [SW-1:0]     rad_s  [NS];
	logic [SW-1:0]     root_s [NS];
	dsf_pkg::sq_side_t side_s [NS];

	genvar j;
	for (j = 0; j < NS; j++) begin : g_st
		localparam logic [SW:0] BIT = (SW+1)'(1) << (2 * (NS - 1 - j));
		logic              pv;
		logic [SW-1:0]     prad;
		logic [SW-1:0]     proot;
		dsf_pkg::sq_side_t pside;
		logic [SW:0]       trial;
		logic              take;

		if (j == 0) begin : g_first
			assign pv    = in_valid;
			assign prad  = in_rad;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[j-1];
			assign prad  = rad_s[j-1];
			assign proot = root_s[j-1];
			assign pside = side_s[j-1];
		end

		assign trial = {1'b0, proot} + BIT;
		assign take  = {1'b0, prad} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j]  <= take ? prad - trial[SW-1:0] : prad;
				root_s[j] <= take ? (proot >> 1) + BIT[SW-1:0] : proot >> 1;
				side_s[j] <= pside;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_root  = root_s[NS-1][dsf_pkg::LEN_W-1:0];
	assign out_side  = side_s[NS-1];

endmodule

>>> hdl/dsf_div.sv
// Pipelined restoring divider, four lanes, one quotient bit per stage.
module dsf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [dsf_pkg::NUM_W-1:0] in_num [dsf_pkg::DIV_LANES],
	input  logic [dsf_pkg::DEN_W-1:0] in_den [dsf_pkg::DIV_LANES],
	input  dsf_pkg::div_side_t        in_side,
	output logic                      out_valid,
	output logic [dsf_pkg::QUO_W-1:0] out_quo [dsf_pkg::DIV_LANES],
	output dsf_pkg::div_side_t        out_side
);

	localparam int unsigned QW = dsf_pkg::QUO_W;
	localparam int unsigned NW = dsf_pkg::NUM_W;
	localparam int unsigned DW = dsf_pkg::DEN_W;
	localparam int unsigned CW = dsf_pkg::NUM_W + 2;
	localparam int unsigned NL = dsf_pkg::DIV_LANES;

	logic               v_s    [QW];
	logic [NW-1:0]      rem_s  [QW][NL];
	logic [DW-1:0]      den_s  [QW][NL];
	logic [QW-1:0]      quo_s  [QW][NL];
	dsf_pkg::div_side_t side_s [QW];

	genvar k, n;
	for (k = 0; k < QW; k++) begin : g_st
		localparam int unsigned B = QW - 1 - k;
		logic               pv;
		dsf_pkg::div_side_t pside;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pside = side_s[k-1];
		end

		for (n = 0; n < NL; n++) begin : g_lane
			logic [NW-1:0] prem;
			logic [DW-1:0] pden;
			logic [QW-1:0] pquo;
			logic [CW-1:0] sh;
			logic          take;
			logic [QW-1:0] quo_n;

			if (k == 0) begin : g_first
				assign prem = in_num[n];
				assign pden = in_den[n];
				assign pquo = '0;
			end else begin : g_next
				assign prem = rem_s[k-1][n];
				assign pden = den_s[k-1][n];
				assign pquo = quo_s[k-1][n];
			end

			assign sh   = CW'(pden) << B;
			assign take = CW'(prem) >= sh;

			always_comb begin
				quo_n    = pquo;
				quo_n[B] = take;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][n] <= take ? prem - sh[NW-1:0] : prem;
					den_s[k][n] <= pden;
					quo_s[k][n] <= quo_n;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= pside;
			end
		end
	end

	for (n = 0; n < NL; n++) begin : g_out
		assign out_quo[n] = quo_s[QW-1][n];
	end

	assign out_valid = v_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule
